// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the pack monitor.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BMFT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in this cycle implies consequent in this cycle.
`define BMFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/bmft_pkg.sv
// Package of the pack monitor: sequencer states, register indexes,
// frame decoding constants and the request struct of the MAC unit.
package bmft_pkg;

  // Frame identifier window and kind masks
  localparam logic [10:0] ID_LOW          = 11'h100;
  localparam logic [10:0] ID_HIGH         = 11'h2FF;
  localparam logic [11:0] CELL_KIND_MASK  = 12'hF00;
  localparam logic [11:0] GROUP_KIND_MASK = 12'hFF0;

  // Fault byte codes
  localparam logic [7:0] FAULT_LINK = 8'h01;
  localparam logic [7:0] FAULT_HOT  = 8'h04;

  // Flag bit positions
  localparam int unsigned FLAG_OV = 0;
  localparam int unsigned FLAG_UV = 1;
  localparam int unsigned FLAG_OT = 2;
  localparam int unsigned FLAG_LL = 3;

  // Pack state codes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SENSOR = 2'd1;
  localparam logic [1:0] MODE_COMMS  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_CELL_BASE   = 3'd0;
  localparam logic [2:0] CFG_TEMP_BASE   = 3'd1;
  localparam logic [2:0] CFG_STATUS_BASE = 3'd2;
  localparam logic [2:0] CFG_OVER_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_UNDER_LIMIT = 3'd4;
  localparam logic [2:0] CFG_LOST_THRESH = 3'd5;
  localparam logic [2:0] CFG_MV_SCALE    = 3'd6;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRAME,
    ST_CELL_WR,
    ST_TICK_CELLS,
    ST_TICK_DRAIN,
    ST_TICK_MON,
    ST_DONE
  } state_e;

  // Request to the multiply-accumulate unit
  typedef struct packed {
    logic        clear;
    logic        valid;
    logic [15:0] code;
  } mac_req_t;

endpackage

// File: rtl/bmft_cell_store.sv
// Cell code store: one write port and one registered read port.
// No dependencies.
module bmft_cell_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bmft_mac.sv
// Shared multiply-accumulate unit: code times Q0.16 scale, then a
// saturating 32-bit sum. Depends on bmft_pkg.
module bmft_mac
  import bmft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_req_t    req_i,
  input  logic [15:0] scale_i,
  output logic [31:0] sum_o,
  output logic        busy_o
);

  logic        prod_vld_q;
  logic [31:0] prod_q;
  logic [31:0] sum_q;
  logic [32:0] sum_ext;

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= 32'(req_i.code) * 32'(scale_i);
  end

  // Accumulate the millivolt part, clamping on carry out
  assign sum_ext = {1'b0, sum_q} + 33'(prod_q[31:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_q      <= '0;
    end else if (req_i.clear) begin
      prod_vld_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      prod_vld_q <= req_i.valid;
      if (prod_vld_q) begin
        sum_q <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      end
    end
  end

  assign sum_o  = sum_q;
  assign busy_o = prod_vld_q;

endmodule

// File: rtl/battery_monitor_frame_and_fault_tracker.sv
// Top level of the pack monitor: frame sorter, tick sequencer, per-monitor
// status registers. Depends on bmft_pkg, bmft_cell_store, bmft_mac, assert_macros.svh.
//
// Usage:
//  - Input stream (s_axis_*): one transaction is a CAN frame (tuser = 0) or an
//    update tick (tuser = 1). Output stream (m_axis_*): one result per input.
//  - Config channel (cfg_*): register index and data, always ready; write only
//    while no input is in progress.
//  - A frame's result follows a decode step (and, for a cell-voltage frame, four write
//    steps, which put four codes through the single write port of the cell store).
//  - A tick's result follows a cell walk, reading one code per cycle into the
//    shared multiplier, a drain, then a check of one monitor per cycle.
//  - One item is in work at a time; the input is ready again once the result
//    is in the output register, even while that result is still unread.
//  - After reset a clearing pass writes zero to every cell entry; no input is
//    taken meanwhile.
//  - If the receiver stalls, the finished result waits in the output register
//    and the sequencer holds in its final step until the register frees.
`include "assert_macros.svh"

module battery_monitor_frame_and_fault_tracker
  import bmft_pkg::*;
#(
  parameter int unsigned MONITORS          = 8,
  parameter int unsigned CELLS_PER_MONITOR = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [10:0] frame_id, [42:11] data_low, [74:43] data_high, [79:75] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] op
  input  logic [0:0]             s_axis_tuser_i,
  // output stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] pack_state, [2] volt_high, [3] volt_low,
  // [4] temp_high, [5] link_lost, [37:6] total_mv, [38] frame_taken, [39] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);

  localparam int unsigned DEPTH = MONITORS * CELLS_PER_MONITOR;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW    = (MONITORS > 1) ? $clog2(MONITORS) : 1;
  localparam int unsigned AXW   = AW + 7;

  // Configuration registers
  logic [11:0] cell_base_q, temp_base_q, status_base_q;
  logic [15:0] over_limit_q, under_limit_q, lost_thresh_q, mv_scale_q;

  // Sequencer and item registers
  state_e        state_q, state_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [MW-1:0] mon_cnt_q, mon_cnt_d;
  logic [1:0]    k_q, k_d;
  logic          rd_vld_q;
  logic          taken_q, taken_d;
  logic [3:0]    flags_acc_q, flags_acc_d;
  logic [10:0]   id_q;
  logic [31:0]   lo_q, hi_q;

  // Held results
  logic [3:0]  flag_q;
  logic [31:0] total_q;
  logic [1:0]  mode_q;

  // Per-monitor registers
  logic [7:0]  fault_q [MONITORS];
  logic [15:0] min_q   [MONITORS];
  logic [15:0] max_q   [MONITORS];
  logic [15:0] lost_q  [MONITORS];

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   out_load;

  // Memory and MAC hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   mem_rdata;
  mac_req_t      mac_req;
  logic [31:0]   mac_sum;
  logic          mac_busy;

  logic in_acc;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_base_q   <= 12'h100;
      temp_base_q   <= 12'h200;
      status_base_q <= 12'h210;
      over_limit_q  <= 16'd42000;
      under_limit_q <= 16'd30000;
      lost_thresh_q <= 16'd10;
      mv_scale_q    <= 16'd6554;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CELL_BASE:   cell_base_q   <= cfg_data_i[11:0];
        CFG_TEMP_BASE:   temp_base_q   <= cfg_data_i[11:0];
        CFG_STATUS_BASE: status_base_q <= cfg_data_i[11:0];
        CFG_OVER_LIMIT:  over_limit_q  <= cfg_data_i;
        CFG_UNDER_LIMIT: under_limit_q <= cfg_data_i;
        CFG_LOST_THRESH: lost_thresh_q <= cfg_data_i;
        CFG_MV_SCALE:    mv_scale_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame decoding
  logic [11:0] id12;
  logic        in_win, is_cell, is_temp, is_stat, mon_ok, frame_hit;
  logic [3:0]  mon;
  logic [MW-1:0] mon_idx;
  assign id12    = {1'b0, id_q};
  assign in_win  = (id_q >= ID_LOW) && (id_q <= ID_HIGH);
  assign is_cell = in_win && ((id12 & CELL_KIND_MASK) == cell_base_q);
  assign is_temp = in_win && !is_cell && ((id12 & GROUP_KIND_MASK) == temp_base_q);
  assign is_stat = in_win && !is_cell && !is_temp
                   && ((id12 & GROUP_KIND_MASK) == status_base_q);
  assign mon       = is_cell ? id_q[7:4] : id_q[3:0];
  assign mon_ok    = ({1'b0, mon} < 5'(MONITORS));
  assign frame_hit = (is_cell || is_temp || is_stat) && mon_ok;
  assign mon_idx   = mon[MW-1:0];

  // Cell address of the current code in a cell frame
  logic [5:0]     cell_idx;
  logic           cell_ok;
  logic [AXW-1:0] cell_addr;
  logic [15:0]    cell_half;
  assign cell_idx  = {id_q[3:0], k_q};
  assign cell_ok   = (7'(cell_idx) < 7'(CELLS_PER_MONITOR));
  assign cell_addr = AXW'(id_q[7:4]) * AXW'(CELLS_PER_MONITOR) + AXW'(cell_idx);

  always_comb begin
    case (k_q)
      2'd0:    cell_half = lo_q[15:0];
      2'd1:    cell_half = lo_q[31:16];
      2'd2:    cell_half = hi_q[15:0];
      default: cell_half = hi_q[31:16];
    endcase
  end

  // Per-monitor check during the tick
  logic [15:0] lost_inc;
  logic [3:0]  mon_flags, flags_next;
  logic [1:0]  mode_next;
  logic        mon_last, walk_last;
  assign lost_inc = (lost_q[mon_cnt_q] == 16'hFFFF) ? 16'hFFFF : lost_q[mon_cnt_q] + 16'd1;
  always_comb begin
    mon_flags          = '0;
    mon_flags[FLAG_OV] = max_q[mon_cnt_q] > over_limit_q;
    mon_flags[FLAG_UV] = min_q[mon_cnt_q] < under_limit_q;
    mon_flags[FLAG_OT] = fault_q[mon_cnt_q] == FAULT_HOT;
    mon_flags[FLAG_LL] = (lost_inc > lost_thresh_q) || (fault_q[mon_cnt_q] == FAULT_LINK);
  end
  assign flags_next = flags_acc_q | mon_flags;
  assign mode_next  = (flags_next[FLAG_OV] || flags_next[FLAG_UV] || flags_next[FLAG_OT])
                      ? MODE_SENSOR : (flags_next[FLAG_LL] ? MODE_COMMS : MODE_NORMAL);
  assign mon_last   = (mon_cnt_q == MW'(MONITORS - 1));
  assign walk_last  = (walk_q == AW'(DEPTH - 1));

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  // Sequencer: next state and unit controls
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    mon_cnt_d   = mon_cnt_q;
    k_d         = k_q;
    taken_d     = taken_q;
    flags_acc_d = flags_acc_q;
    mem_we      = 1'b0;
    mem_waddr   = walk_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mac_req     = '{clear: 1'b0, valid: rd_vld_q, code: mem_rdata};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        walk_d = walk_q + AW'(1);
        if (walk_last) begin
          walk_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          taken_d     = 1'b0;
          walk_d      = '0;
          mon_cnt_d   = '0;
          k_d         = '0;
          flags_acc_d = '0;
          if (s_axis_tuser_i[0]) begin
            mac_req.clear = 1'b1;
            state_d       = ST_TICK_CELLS;
          end else begin
            state_d = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        taken_d = frame_hit;
        state_d = (frame_hit && is_cell) ? ST_CELL_WR : ST_DONE;
      end
      ST_CELL_WR: begin
        mem_we    = cell_ok;
        mem_waddr = cell_addr[AW-1:0];
        mem_wdata = cell_half;
        k_d       = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_TICK_CELLS: begin
        mem_re = 1'b1;
        walk_d = walk_q + AW'(1);
        if (walk_last) begin
          walk_d  = '0;
          state_d = ST_TICK_DRAIN;
        end
      end
      ST_TICK_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = ST_TICK_MON;
        end
      end
      ST_TICK_MON: begin
        flags_acc_d = flags_next;
        mon_cnt_d   = mon_cnt_q + MW'(1);
        if (mon_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      walk_q      <= '0;
      mon_cnt_q   <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      taken_q     <= 1'b0;
      flags_acc_q <= '0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      mon_cnt_q   <= mon_cnt_d;
      k_q         <= k_d;
      rd_vld_q    <= mem_re;
      taken_q     <= taken_d;
      flags_acc_q <= flags_acc_d;
    end
  end

  // Captured input payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q <= s_axis_tdata_i[10:0];
      lo_q <= s_axis_tdata_i[42:11];
      hi_q <= s_axis_tdata_i[74:43];
    end
  end

  // Per-monitor status and lost counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MONITORS; i++) begin
        fault_q[i] <= '0;
        min_q[i]   <= '0;
        max_q[i]   <= '0;
        lost_q[i]  <= '0;
      end
    end else if (state_q == ST_FRAME && frame_hit) begin
      lost_q[mon_idx] <= '0;
      if (is_stat) begin
        fault_q[mon_idx] <= lo_q[7:0];
        min_q[mon_idx]   <= hi_q[15:0];
        max_q[mon_idx]   <= hi_q[31:16];
      end
    end else if (state_q == ST_TICK_MON) begin
      lost_q[mon_cnt_q] <= lost_inc;
    end
  end

  // Held pack results, updated at the end of a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= '0;
      total_q <= '0;
      mode_q  <= MODE_NORMAL;
    end else if (state_q == ST_TICK_MON && mon_last) begin
      flag_q  <= flags_next;
      total_q <= mac_sum;
      mode_q  <= mode_next;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {1'b0, taken_q, total_q, flag_q[FLAG_LL], flag_q[FLAG_OT],
                   flag_q[FLAG_UV], flag_q[FLAG_OV], mode_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  bmft_cell_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (walk_q),
    .rdata_o (mem_rdata)
  );

  bmft_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mac_req),
    .scale_i (mv_scale_q),
    .sum_o   (mac_sum),
    .busy_o  (mac_busy)
  );

  // Assertion helpers
  logic we_ok, rd_ok, mac_idle;
  assign we_ok    = (state_q == ST_CLEAR) || (state_q == ST_CELL_WR);
  assign rd_ok    = (state_q == ST_TICK_CELLS) || (state_q == ST_TICK_DRAIN);
  assign mac_idle = !mac_busy && !rd_vld_q;

  // Cell store is only written by the clearing pass and by cell frames
  `BMFT_ASSERT_IMP(a_we_state, clk_i, rst_ni, mem_we, we_ok, "cell store written out of turn")
  // Accumulator pipeline is empty whenever a new item may enter
  `BMFT_ASSERT_IMP(a_idle_mac, clk_i, rst_ni, s_axis_tready_o, mac_idle, "MAC busy in idle")
  // Read data only flows during the cell walk and its drain
  `BMFT_ASSERT(a_rd_tick, clk_i, rst_ni, rd_vld_q |-> rd_ok, "cell read outside tick walk")

endmodule

// File: tb/pack_monitor_checker.sv
`timescale 1ns / 1ps
// Checker for the pack monitor: watches the input, output and register channels,
// keeps its own copy of the monitor state and compares every result transaction.
// Depends on bmft_pkg for stream widths, register indexes and decode constants.
module pack_monitor_checker
  import bmft_pkg::*;
#(
  parameter int unsigned MONITORS          = 8,
  parameter int unsigned CELLS_PER_MONITOR = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  // [10:0] frame_id, [42:11] data_low, [74:43] data_high, [79:75] zero
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  // [0] op
  input  logic [0:0]             in_user_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  // [1:0] pack_state, [2] volt_high, [3] volt_low, [4] temp_high,
  // [5] link_lost, [37:6] total_mv, [38] frame_taken, [39] zero
  input  logic [OUT_TDATA_W-1:0] out_data_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  output int                     pending_o,
  output int                     errors_o
);

  localparam int unsigned CODES = MONITORS * CELLS_PER_MONITOR;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] data_high;
    logic [31:0] data_low;
    logic [10:0] frame_id;
  } can_item_t;

  typedef struct packed {
    logic        pad;
    logic        frame_taken;
    logic [31:0] total_mv;
    logic        link_lost;
    logic        temp_high;
    logic        volt_low;
    logic        volt_high;
    logic [1:0]  pack_state;
  } pack_report_t;

  // Register copies
  logic [11:0] cell_base, temp_base, status_base;
  logic [15:0] over_limit, under_limit, lost_limit, mv_scale;

  // Monitor state as the block should hold it
  logic [15:0] code_mem     [CODES];
  logic [7:0]  fault_byte   [MONITORS];
  logic [15:0] floor_code   [MONITORS];
  logic [15:0] peak_code    [MONITORS];
  logic [15:0] silent_ticks [MONITORS];
  logic [3:0]  flags_q;
  logic [31:0] total_q;
  logic [1:0]  mode_q;

  pack_report_t awaited_reports [$];
  pack_report_t want_report;
  can_item_t    seen_item;
  int           printed = 0;

  // One line per mismatch; printing stops after 100 but counting goes on
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors_o++;
    if (printed < 100) begin
      printed++;
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic clear_model();
    cell_base   = 12'h100;
    temp_base   = 12'h200;
    status_base = 12'h210;
    over_limit  = 16'd42000;
    under_limit = 16'd30000;
    lost_limit  = 16'd10;
    mv_scale    = 16'd6554;
    foreach (code_mem[i]) code_mem[i] = '0;
    for (int m = 0; m < MONITORS; m++) begin
      fault_byte[m]   = '0;
      floor_code[m]   = '0;
      peak_code[m]    = '0;
      silent_ticks[m] = '0;
    end
    flags_q = '0;
    total_q = '0;
    mode_q  = MODE_NORMAL;
  endtask

  // Register write: ID bases keep 12 bits, unknown index is dropped
  task automatic apply_setting(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      CFG_CELL_BASE:   cell_base   = data[11:0];
      CFG_TEMP_BASE:   temp_base   = data[11:0];
      CFG_STATUS_BASE: status_base = data[11:0];
      CFG_OVER_LIMIT:  over_limit  = data;
      CFG_UNDER_LIMIT: under_limit = data;
      CFG_LOST_THRESH: lost_limit  = data;
      CFG_MV_SCALE:    mv_scale    = data;
      default: ;
    endcase
  endtask

  // Frame sorting: cell kind first, then temperature, then status
  task automatic sort_frame(input logic [10:0] id, input logic [31:0] lo,
                            input logic [31:0] hi, output logic taken);
    logic [11:0] id12;
    logic [63:0] payload;
    int unsigned mon;
    int unsigned slot;
    id12    = {1'b0, id};
    payload = {hi, lo};
    taken   = 1'b0;
    if (id < ID_LOW || id > ID_HIGH) return;
    if ((id12 & CELL_KIND_MASK) == cell_base) begin
      mon = id12[7:4];
      if (mon < MONITORS) begin
        silent_ticks[mon] = '0;
        for (int k = 0; k < 4; k++) begin
          slot = id12[3:0] * 4 + k;
          if (slot < CELLS_PER_MONITOR)
            code_mem[mon * CELLS_PER_MONITOR + slot] = payload[16*k +: 16];
        end
        taken = 1'b1;
      end
    end else if ((id12 & GROUP_KIND_MASK) == temp_base) begin
      mon = id12[3:0];
      if (mon < MONITORS) begin
        silent_ticks[mon] = '0;
        taken = 1'b1;
      end
    end else if ((id12 & GROUP_KIND_MASK) == status_base) begin
      mon = id12[3:0];
      if (mon < MONITORS) begin
        silent_ticks[mon] = '0;
        fault_byte[mon]   = payload[7:0];
        floor_code[mon]   = payload[47:32];
        peak_code[mon]    = payload[63:48];
        taken = 1'b1;
      end
    end
  endtask

  // Tick: scaled saturating sum, voltage flags, lost counters, fault decode
  task automatic run_tick();
    logic [32:0] sum;
    logic [31:0] prod;
    logic [3:0]  f;
    sum = '0;
    f   = '0;
    for (int m = 0; m < MONITORS; m++) begin
      for (int c = 0; c < CELLS_PER_MONITOR; c++) begin
        prod = code_mem[m * CELLS_PER_MONITOR + c] * mv_scale;
        sum  = sum + prod[31:16];
        if (sum[32]) sum = 33'h0_FFFF_FFFF;
      end
      if (peak_code[m] > over_limit)   f[FLAG_OV] = 1'b1;
      if (floor_code[m] < under_limit) f[FLAG_UV] = 1'b1;
    end
    for (int m = 0; m < MONITORS; m++) begin
      if (silent_ticks[m] != 16'hFFFF) silent_ticks[m]++;
      if (silent_ticks[m] > lost_limit) f[FLAG_LL] = 1'b1;
      if (fault_byte[m] == FAULT_LINK) f[FLAG_LL] = 1'b1;
      else if (fault_byte[m] == FAULT_HOT) f[FLAG_OT] = 1'b1;
    end
    total_q = sum[31:0];
    flags_q = f;
    if (f[FLAG_OV] || f[FLAG_UV] || f[FLAG_OT]) mode_q = MODE_SENSOR;
    else if (f[FLAG_LL])                          mode_q = MODE_COMMS;
    else                                          mode_q = MODE_NORMAL;
  endtask

  task automatic predict_pack_report(input logic op, input can_item_t it,
                                     output pack_report_t rep);
    logic taken;
    taken = 1'b0;
    if (op) run_tick();
    else    sort_frame(it.frame_id, it.data_low, it.data_high, taken);
    rep             = '0;
    rep.pack_state  = mode_q;
    rep.volt_high   = flags_q[FLAG_OV];
    rep.volt_low    = flags_q[FLAG_UV];
    rep.temp_high   = flags_q[FLAG_OT];
    rep.link_lost   = flags_q[FLAG_LL];
    rep.total_mv    = total_q;
    rep.frame_taken = taken;
  endtask

  task automatic check_report(input pack_report_t got);
    pack_report_t want;
    if (awaited_reports.size() == 0) begin
      note_mismatch("result with nothing awaited", got.total_mv, '0);
      return;
    end
    want = awaited_reports.pop_front();
    if (got.pack_state !== want.pack_state)
      note_mismatch("pack_state", got.pack_state, want.pack_state);
    if (got.volt_high !== want.volt_high)
      note_mismatch("volt_high", got.volt_high, want.volt_high);
    if (got.volt_low !== want.volt_low)
      note_mismatch("volt_low", got.volt_low, want.volt_low);
    if (got.temp_high !== want.temp_high)
      note_mismatch("temp_high", got.temp_high, want.temp_high);
    if (got.link_lost !== want.link_lost)
      note_mismatch("link_lost", got.link_lost, want.link_lost);
    if (got.total_mv !== want.total_mv)
      note_mismatch("total_mv", got.total_mv, want.total_mv);
    if (got.frame_taken !== want.frame_taken)
      note_mismatch("frame_taken", got.frame_taken, want.frame_taken);
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      awaited_reports.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_setting(cfg_index_i, cfg_data_i);
      if (out_valid_i && out_ready_i) check_report(pack_report_t'(out_data_i));
      if (in_valid_i && in_ready_i) begin
        seen_item = can_item_t'(in_data_i);
        predict_pack_report(in_user_i[0], seen_item, want_report);
        awaited_reports.push_back(want_report);
      end
      pending_o = awaited_reports.size();
    end
  end

endmodule

// File: tb/battery_monitor_frame_and_fault_tracker_tb.sv
`timescale 1ns / 1ps
// Testbench top of the pack monitor: clock, reset, frame and tick stimulus,
// register phases and stalls. Depends on bmft_pkg, the RTL and pack_monitor_checker.
module battery_monitor_frame_and_fault_tracker_tb
  import bmft_pkg::*;
;

  localparam int unsigned MONITORS          = 8;
  localparam int unsigned CELLS_PER_MONITOR = 64;
  localparam logic [2:0]  CFG_UNUSED        = 3'd7;
  localparam int          HOLD_CYCLES       = 1500;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [IN_TDATA_W-1:0]  in_data    = '0;
  logic [0:0]             in_user    = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b1;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index  = '0;
  logic [15:0]            cfg_data   = '0;
  int                     pending;
  int                     errors;

  logic        calm       = 1'b0;  // no idling on either side
  logic        hold_out   = 1'b0;  // request for one long receiver stall
  logic [15:0] cfg_now [0:6];
  int          items_sent = 0;
  int          ticks_sent = 0;

  always #4 clk = ~clk;

  battery_monitor_frame_and_fault_tracker #(
    .MONITORS          (MONITORS),
    .CELLS_PER_MONITOR (CELLS_PER_MONITOR)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  pack_monitor_checker #(
    .MONITORS          (MONITORS),
    .CELLS_PER_MONITOR (CELLS_PER_MONITOR)
  ) u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .in_user_i   (in_user),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Offer one item, with an optional idle burst first; returns on its transaction
  task automatic send_item(input logic op, input logic [10:0] id,
                           input logic [31:0] lo, input logic [31:0] hi);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_user  = op;
    in_data  = {5'd0, hi, lo, id};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op) ticks_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx != CFG_UNUSED) cfg_now[idx] = data;
  endtask

  task automatic load_settings(input logic [15:0] cb, input logic [15:0] tb,
                               input logic [15:0] sb, input logic [15:0] ov,
                               input logic [15:0] uv, input logic [15:0] lt,
                               input logic [15:0] sc);
    drain();
    write_reg(CFG_CELL_BASE,   cb);
    write_reg(CFG_TEMP_BASE,   tb);
    write_reg(CFG_STATUS_BASE, sb);
    write_reg(CFG_OVER_LIMIT,  ov);
    write_reg(CFG_UNDER_LIMIT, uv);
    write_reg(CFG_LOST_THRESH, lt);
    write_reg(CFG_MV_SCALE,    sc);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Code close to a limit, or anywhere
  function automatic logic [15:0] near_limit(input logic [15:0] lim);
    case ($urandom_range(0, 3))
      0:       return lim - 16'd1;
      1:       return lim;
      2:       return lim + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly frames aimed at the current ID bases, some ticks and some noise IDs
  task automatic run_random(input int n, input int hold_at, input int drain_at);
    int          r;
    logic [3:0]  mon;
    logic [10:0] id;
    logic [31:0] lo, hi;
    logic        op;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_out = 1'b1;
      if (i == drain_at) drain();
      r   = $urandom_range(0, 99);
      mon = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                        : 4'($urandom_range(0, 7));
      lo  = $urandom;
      hi  = $urandom;
      op  = 1'b0;
      if (r < 10) begin
        op = 1'b1;
        id = 11'($urandom);
      end else if (r < 40) begin
        id = {cfg_now[CFG_CELL_BASE][10:8], mon, 4'($urandom)};
      end else if (r < 55) begin
        id = {cfg_now[CFG_TEMP_BASE][10:4], mon};
      end else if (r < 80) begin
        id = {cfg_now[CFG_STATUS_BASE][10:4], mon};
        case ($urandom_range(0, 3))
          0:       lo[7:0] = FAULT_LINK;
          1:       lo[7:0] = FAULT_HOT;
          2:       lo[7:0] = 8'h00;
          default: lo[7:0] = 8'($urandom);
        endcase
        hi = {near_limit(cfg_now[CFG_OVER_LIMIT]), near_limit(cfg_now[CFG_UNDER_LIMIT])};
      end else begin
        id = 11'($urandom);
      end
      send_item(op, id, lo, hi);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out  = 1'b0;
        out_ready = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Timeout for a hung run, set well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    cfg_now[CFG_CELL_BASE]   = 16'h0100;
    cfg_now[CFG_TEMP_BASE]   = 16'h0200;
    cfg_now[CFG_STATUS_BASE] = 16'h0210;
    cfg_now[CFG_OVER_LIMIT]  = 16'd42000;
    cfg_now[CFG_UNDER_LIMIT] = 16'd30000;
    cfg_now[CFG_LOST_THRESH] = 16'd10;
    cfg_now[CFG_MV_SCALE]    = 16'd6554;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: a silent pack first, then every kind
    send_item(1'b1, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 11'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 11'h17F, 32'hA5A5_5A5A, 32'h0001_8000);
    send_item(1'b0, 11'h180, 32'h1234_5678, 32'h9ABC_DEF0);  // monitor beyond count
    send_item(1'b0, 11'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 11'h200, 32'h0, 32'h0);                  // temperature
    send_item(1'b0, 11'h208, 32'h0, 32'h0);
    send_item(1'b0, 11'h213, {24'h0, FAULT_HOT}, {16'd45000, 16'd20000});
    send_item(1'b0, 11'h21F, {24'h0, FAULT_LINK}, 32'h0);
    send_item(1'b0, 11'h0FF, 32'h0, 32'h0);                  // below the window
    send_item(1'b0, 11'h300, 32'h0, 32'h0);                  // above the window
    send_item(1'b0, 11'h7FF, 32'h0, 32'h0);
    send_item(1'b0, 11'h000, 32'h0, 32'h0);
    send_item(1'b0, 11'h220, 32'h0, 32'h0);                  // in window, no kind
    send_item(1'b1, 11'h000, 32'h0, 32'h0);
    // All monitors healthy gives a normal pack, then one reports a lost link
    for (int m = 0; m < MONITORS; m++)
      send_item(1'b0, 11'(11'h210 + m), 32'h0, {16'd40000, 16'd35000});
    send_item(1'b1, 11'h000, 32'h0, 32'h0);
    send_item(1'b0, 11'h212, {24'h0, FAULT_LINK}, {16'd40000, 16'd35000});
    send_item(1'b1, 11'h000, 32'h0, 32'h0);

    run_random(200, -1, -1);

    // Extremes: upper base bits set to show masking, limits at the ends
    load_settings(16'hF200, 16'h01F0, 16'h0120, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_random(200, 50, -1);

    load_settings(16'hFF00, 16'h02F0, 16'h0100, 16'hFFFF, 16'd0, 16'd65534, 16'd0);
    run_random(200, -1, 100);

    // Unknown index is written too; temperature and status bases swapped
    drain();
    write_reg(CFG_UNUSED, 16'hBEEF);
    load_settings(16'h0100, 16'h0210, 16'h0200, 16'd40000, 16'd32000, 16'd3, 16'd6554);
    run_random(200, -1, -1);

    // Random settings, back-to-back transactions on both sides
    load_settings(16'(($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 2)) << 8),
                  16'($urandom_range(16'h10, 16'h2F) << 4),
                  16'($urandom_range(16'h10, 16'h2F) << 4),
                  16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 12)), 16'($urandom));
    calm = 1'b1;
    run_random(200, -1, -1);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Run covered %0d items (%0d ticks) under five register settings,", items_sent,
             ticks_sent);
    $display("with cell, temperature, status and stray frames and stalls on both sides.");
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
